### design/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the four-bone weight selector.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int KEEP_DEFAULT = 4;
    localparam int OUT_SLOTS    = 4;
    localparam int SLOT_W       = $clog2(OUT_SLOTS);
    localparam int DATA_W       = 16;
    localparam int DIV_STEPS    = DATA_W + 1;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam logic [DATA_W-1:0] SHARE_MAX = {DATA_W{1'b1}};

    typedef struct packed {
        logic              present;
        logic [DATA_W-1:0] bone_index;
        logic [DATA_W-1:0] influence_weight;
        logic              last;
    } tws_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] bone_0;
        logic [DATA_W-1:0] bone_1;
        logic [DATA_W-1:0] bone_2;
        logic [DATA_W-1:0] bone_3;
        logic [DATA_W-1:0] share_0;
        logic [DATA_W-1:0] share_1;
        logic [DATA_W-1:0] share_2;
        logic [DATA_W-1:0] share_3;
    } tws_out_t;

    typedef struct packed {
        logic              insert;
        logic              div_step;
        logic              step_first;
        logic              step_last;
        logic [SLOT_W-1:0] slot;
        logic              publish;
    } tws_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } tws_state_t;

endpackage

### design/tws_ctrl.sv
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer: accepts influences, steps the shared divider over the four
// output slots and hands the result to the output register.
// ----------------------------------------------------------------------------
module tws_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_present,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output tws_pkg::tws_cmd_t cmd
);
    import tws_pkg::*;

    tws_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              step_last;
    logic              publish;

    assign step_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign publish   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_DIV;
                    slot_next  = '0;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (step_last)
                begin
                    step_next = '0;
                    if (slot_reg == SLOT_W'(OUT_SLOTS - 1))
                        state_next = ST_DONE;
                    else
                        slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (publish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_comb
    begin
        cmd.insert     = in_valid && in_ready && in_present;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.step_first = (step_reg == '0);
        cmd.step_last  = step_last;
        cmd.slot       = slot_reg;
        cmd.publish    = publish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/tws_dp.sv
// ----------------------------------------------------------------------------
// tws_dp
// Datapath: sorted store of kept influences with running sum, a one bit per
// cycle restoring divider and the output register.
// ----------------------------------------------------------------------------
module tws_dp #(
    parameter int KEEP = tws_pkg::KEEP_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tws_pkg::tws_cmd_t cmd,
    input  tws_pkg::tws_in_t  in_data,
    output tws_pkg::tws_out_t out_data
);
    import tws_pkg::*;

    localparam int CW = $clog2(KEEP + 1);
    localparam int SW = DATA_W + $clog2(KEEP);

    logic [DATA_W-1:0] bone_reg   [KEEP];
    logic [DATA_W-1:0] weight_reg [KEEP];
    logic [DATA_W-1:0] bone_next  [KEEP];
    logic [DATA_W-1:0] weight_next[KEEP];
    logic [CW-1:0]     count_reg;
    logic [SW-1:0]     sum_reg;
    logic [KEEP-1:0]   ge;

    logic [DATA_W-1:0] slot_bone  [OUT_SLOTS];
    logic [DATA_W-1:0] slot_weight[OUT_SLOTS];
    logic [DATA_W-1:0] share_reg  [OUT_SLOTS];

    logic [SW-1:0]     rem_reg;
    logic [DIV_STEPS-2:0] quo_reg;
    logic [DATA_W-1:0] div_w;
    logic [SW-1:0]     rem_in;
    logic              bit_in;
    logic [SW:0]       trial;
    logic [SW:0]       diff;
    logic              take;
    logic [DIV_STEPS-1:0] quo_full;
    logic              zero_sum;
    tws_out_t          out_reg;

    // insertion: an equal weight stays ahead of the new pair
    genvar gi;
    generate
        for (gi = 0; gi < KEEP; gi++)
        begin : g_slot
            assign ge[gi] = (CW'(gi) < count_reg) &&
                            (weight_reg[gi] >= in_data.influence_weight);
            if (gi == 0)
            begin : g_first
                always_comb
                begin
                    if (ge[gi])
                    begin
                        bone_next[gi]   = bone_reg[gi];
                        weight_next[gi] = weight_reg[gi];
                    end
                    else
                    begin
                        bone_next[gi]   = in_data.bone_index;
                        weight_next[gi] = in_data.influence_weight;
                    end
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    if (ge[gi])
                    begin
                        bone_next[gi]   = bone_reg[gi];
                        weight_next[gi] = weight_reg[gi];
                    end
                    else if (ge[gi-1])
                    begin
                        bone_next[gi]   = in_data.bone_index;
                        weight_next[gi] = in_data.influence_weight;
                    end
                    else
                    begin
                        bone_next[gi]   = bone_reg[gi-1];
                        weight_next[gi] = weight_reg[gi-1];
                    end
                end
            end
        end

        for (gi = 0; gi < OUT_SLOTS; gi++)
        begin : g_out
            if (gi < KEEP)
            begin : g_used
                assign slot_bone[gi]   = bone_reg[gi];
                assign slot_weight[gi] = weight_reg[gi];
            end
            else
            begin : g_unused
                assign slot_bone[gi]   = '0;
                assign slot_weight[gi] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEEP; i++)
            begin
                bone_reg[i]   <= '0;
                weight_reg[i] <= '0;
            end
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.publish)
        begin
            for (int i = 0; i < KEEP; i++)
            begin
                bone_reg[i]   <= '0;
                weight_reg[i] <= '0;
            end
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.insert && !ge[KEEP-1])
        begin
            for (int i = 0; i < KEEP; i++)
            begin
                bone_reg[i]   <= bone_next[i];
                weight_reg[i] <= weight_next[i];
            end
            if (count_reg != CW'(KEEP))
                count_reg <= count_reg + 1'b1;
            sum_reg <= sum_reg + SW'(in_data.influence_weight) - SW'(weight_reg[KEEP-1]);
        end
    end

    // restoring divider, weight * 2^16 / sum, one quotient bit per cycle
    assign div_w    = slot_weight[cmd.slot];
    assign rem_in   = cmd.step_first ? SW'(div_w[DATA_W-1:1]) : rem_reg;
    assign bit_in   = cmd.step_first ? div_w[0] : 1'b0;
    assign trial    = {rem_in, bit_in};
    assign diff     = trial - {1'b0, sum_reg};
    assign take     = (trial >= {1'b0, sum_reg});
    assign quo_full = {quo_reg, take};
    assign zero_sum = (sum_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.div_step)
        begin
            rem_reg <= take ? diff[SW-1:0] : trial[SW-1:0];
            quo_reg <= quo_full[DIV_STEPS-2:0];
            if (cmd.step_last)
                share_reg[cmd.slot] <= quo_full[DIV_STEPS-1] ? SHARE_MAX
                                                             : quo_full[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.bone_0  <= zero_sum ? '0 : slot_bone[0];
            out_reg.bone_1  <= zero_sum ? '0 : slot_bone[1];
            out_reg.bone_2  <= zero_sum ? '0 : slot_bone[2];
            out_reg.bone_3  <= zero_sum ? '0 : slot_bone[3];
            out_reg.share_0 <= zero_sum ? '0 : share_reg[0];
            out_reg.share_1 <= zero_sum ? '0 : share_reg[1];
            out_reg.share_2 <= zero_sum ? '0 : share_reg[2];
            out_reg.share_3 <= zero_sum ? '0 : share_reg[3];
        end
    end

    assign out_data = out_reg;

endmodule

### design/top4_weight_select_normalize.sv
// ----------------------------------------------------------------------------
// top4_weight_select_normalize
// Keeps the four largest bone influences of a vertex and normalizes them.
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one influence per transaction (bone, weight, present,
//   last); present low adds nothing, last closes the vertex
//   influences are taken one per cycle while in_ready is high; each is sorted
//   into the store in the cycle it is accepted
//   after the last transaction the block is busy: the shared divider produces
//   one quotient bit per cycle for each of the four slots in turn, then the
//   result is loaded into the output register
//   output channel carries one result per vertex: four bones largest first and
//   their shares in Q0.16, zero in unused slots and all zero on a zero sum
//   the output register lets the next vertex stream in while a result waits;
//   if a second vertex finishes while the receiver stalls, the block holds
//   in_ready low until the pending result is taken
//   reset empties the store and drops any pending result
// ----------------------------------------------------------------------------
module top4_weight_select_normalize #(
    parameter int KEEP = tws_pkg::KEEP_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tws_pkg::tws_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tws_pkg::tws_out_t out_data
);
    import tws_pkg::*;

    tws_cmd_t cmd;

    tws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_present (in_data.present),
        .in_last    (in_data.last),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    tws_dp #(
        .KEEP (KEEP)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

### design/tws_chk.sv
// ----------------------------------------------------------------------------
// tws_chk
// Port-level checks for the weight selector, bound to the top level.
// ----------------------------------------------------------------------------
module tws_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input tws_pkg::tws_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input tws_pkg::tws_out_t out_data
);
    import tws_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last |=> !in_ready)
        else $error("input taken while normalizing");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without normalization");

    a_share_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.share_0 >= out_data.share_1) &&
                      (out_data.share_1 >= out_data.share_2) &&
                      (out_data.share_2 >= out_data.share_3))
        else $error("shares out of order");

endmodule

bind top4_weight_select_normalize tws_chk u_tws_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
